FILE: rtl/lspg_pkg.sv
`timescale 1ns / 1ps

package lspg_pkg;

  // Strip geometry and field widths.
  localparam int unsigned MAX_PIXELS = 64;
  localparam int unsigned IDX_W      = $clog2(MAX_PIXELS);
  localparam int unsigned CNT_W      = 7;
  localparam int unsigned STEP_W     = 11;
  localparam int unsigned RGB_W      = 24;
  localparam int unsigned CH_W       = 8;
  localparam int unsigned QUOT_W     = 9;
  localparam int unsigned MODE_W     = 3;

  // Sequence limits.
  localparam logic [STEP_W-1:0] CYCLE_STEPS   = STEP_W'(256 * 5);
  localparam logic [3:0]        CHASE_ROUNDS  = 4'd10;
  localparam logic [1:0]        CHASE_PHASES  = 2'd3;
  localparam logic [8:0]        WHEEL_SPAN    = 9'd255;
  localparam logic [CNT_W-1:0]  MAX_COUNT     = CNT_W'(MAX_PIXELS);

  // Reset values of the configuration registers.
  localparam logic [MODE_W-1:0] MODE_RESET  = 3'd1;
  localparam logic [RGB_W-1:0]  SOLID_RESET = 24'hFF0000;
  localparam logic [CNT_W-1:0]  COUNT_RESET = 7'd60;

  // Animation modes.
  localparam logic [MODE_W-1:0] MODE_WIPE     = 3'd0;
  localparam logic [MODE_W-1:0] MODE_RAINBOW  = 3'd1;
  localparam logic [MODE_W-1:0] MODE_CYCLE    = 3'd2;
  localparam logic [MODE_W-1:0] MODE_CHASE    = 3'd3;
  localparam logic [MODE_W-1:0] MODE_CHASE_RB = 3'd4;

  typedef enum logic [1:0] {
    CFG_MODE        = 2'd0,
    CFG_SOLID_COLOR = 2'd1,
    CFG_PIXEL_COUNT = 2'd2
  } cfg_reg_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_RUN
  } state_e;

  // Result of the per-frame division of 256 by the pixel count.
  typedef struct packed {
    logic              done;
    logic [QUOT_W-1:0] quot;
    logic [CNT_W-1:0]  rem;
  } div_res_t;

  // Colour wheel: red to green, green to blue, blue to red.
  function automatic logic [RGB_W-1:0] wheel(input logic [CH_W-1:0] pos);
    logic [CH_W-1:0] p;
    logic [CH_W-1:0] t;
    logic [CH_W-1:0] m;
    p = ~pos;
    if (p < 8'd85) begin
      t = p;
      m = (t << 1) + t;
      wheel = {8'd255 - m, 8'd0, m};
    end else if (p < 8'd170) begin
      t = p - 8'd85;
      m = (t << 1) + t;
      wheel = {8'd0, m, 8'd255 - m};
    end else begin
      t = p - 8'd170;
      m = (t << 1) + t;
      wheel = {m, 8'd255 - m, 8'd0};
    end
  endfunction

endpackage

FILE: rtl/lspg_ram.sv
`timescale 1ns / 1ps

module lspg_ram #(
  parameter int unsigned Width = 24,
  parameter int unsigned Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/lspg_div.sv
`timescale 1ns / 1ps

// Restoring divider for 256 / divisor, one quotient bit per cycle.
module lspg_div (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [lspg_pkg::CNT_W-1:0]    divisor_i,
  output lspg_pkg::div_res_t            res_o
);

  logic                          busy_q, busy_d;
  logic                          done_q, done_d;
  logic [3:0]                    cnt_q, cnt_d;
  logic [lspg_pkg::CNT_W-1:0]    rem_q, rem_d;
  logic [lspg_pkg::QUOT_W-1:0]   quot_q, quot_d;
  logic [lspg_pkg::CNT_W:0]      trial;
  logic                          ge;

  always_comb begin
    busy_d = busy_q;
    done_d = done_q;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quot_d = quot_q;
    trial  = {rem_q, quot_q[lspg_pkg::QUOT_W-1]};
    ge     = trial >= {1'b0, divisor_i};
    if (start_i) begin
      busy_d = 1'b1;
      done_d = 1'b0;
      cnt_d  = '0;
      rem_d  = '0;
      quot_d = lspg_pkg::QUOT_W'(256);
    end else if (busy_q) begin
      rem_d  = ge ? lspg_pkg::CNT_W'(trial - {1'b0, divisor_i})
                  : lspg_pkg::CNT_W'(trial);
      quot_d = {quot_q[lspg_pkg::QUOT_W-2:0], ge};
      cnt_d  = cnt_q + 4'd1;
      if (cnt_q == 4'(lspg_pkg::QUOT_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    quot_q <= quot_d;
  end

  assign res_o.done = done_q;
  assign res_o.quot = quot_q;
  assign res_o.rem  = rem_q;

endmodule

FILE: rtl/led_strip_pattern_generator.sv
`timescale 1ns / 1ps

// LED strip pattern generator. Each input word is one frame tick: the block
// advances the selected animation (colour wipe, rainbow, rainbow cycle,
// theater chase or theater chase rainbow) and then streams every pixel of
// the strip, index 0 first, with last_pixel_o marking the final one. The
// frame buffer lives in a 64 x 24 synchronous RAM; each pixel is read,
// recoloured on the way out and written back in a single pass. Each frame
// starts with a serial divider that works out 256 / n for the rainbow
// cycle spacing; the pixels then pass through the registered RAM read and
// the output register. A new frame tick is taken once the last pixel of
// the previous frame has left the read stage; the final pixel may still
// be waiting in the output register. The buffer reads as all pixels off
// after reset through per-entry valid flags, so no clearing pass is
// needed. Configuration (mode, solid colour, pixel count) must only be
// written while the block is idle. A pixel count of zero is treated as
// one and counts above 64 as 64.
module led_strip_pattern_generator (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic                              restart_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [lspg_pkg::IDX_W-1:0]        pixel_index_o,
  output logic [lspg_pkg::CH_W-1:0]         red_o,
  output logic [lspg_pkg::CH_W-1:0]         green_o,
  output logic [lspg_pkg::CH_W-1:0]         blue_o,
  output logic                              last_pixel_o,
  input  logic                              cfg_we_i,
  input  logic [1:0]                        cfg_index_i,
  input  logic [lspg_pkg::RGB_W-1:0]        cfg_data_i
);

  // Configuration registers.
  logic [lspg_pkg::MODE_W-1:0] mode_q;
  logic [lspg_pkg::RGB_W-1:0]  solid_q;
  logic [lspg_pkg::CNT_W-1:0]  count_q;

  // Animation counters.
  logic [lspg_pkg::STEP_W-1:0] step_q, step_d;
  logic [1:0]                  phase_q, phase_d;
  logic [3:0]                  round_q, round_d;

  // Frame sequencer.
  lspg_pkg::state_e            state_q, state_d;
  logic [lspg_pkg::IDX_W-1:0]  pix_q, pix_d;
  logic [1:0]                  pm3_q, pm3_d;
  logic [lspg_pkg::QUOT_W-1:0] acc_q, acc_d;
  logic [lspg_pkg::CNT_W-1:0]  racc_q, racc_d;
  logic                        div_start;
  lspg_pkg::div_res_t          div_res;

  // Effective pixel count.
  logic [lspg_pkg::CNT_W-1:0]  n_eff;
  logic [lspg_pkg::IDX_W-1:0]  n_m1;

  // Read stage and output register.
  logic                        s1_vld_q;
  logic [lspg_pkg::IDX_W-1:0]  p1_q;
  logic                        last1_q, lit1_q, hit1_q, ent1_q;
  logic [lspg_pkg::CH_W-1:0]   wpos1_q;
  logic                        out_valid_q;
  logic [lspg_pkg::IDX_W-1:0]  out_idx_q;
  logic [lspg_pkg::RGB_W-1:0]  out_rgb_q;
  logic                        out_last_q;

  // Per-entry valid flags: an entry never written reads as black.
  logic [lspg_pkg::MAX_PIXELS-1:0] ent_vld_q;

  logic                        adv, issue;
  logic [lspg_pkg::STEP_W-1:0] s_pre, s_inc;
  logic [1:0]                  ph_pre;
  logic [3:0]                  rd_pre, r_inc;
  logic [lspg_pkg::CNT_W:0]    rsum;
  logic [lspg_pkg::IDX_W-1:0]  ci;
  logic [8:0]                  csum, cmod;
  logic [lspg_pkg::CH_W-1:0]   wpos0;
  logic                        lit0;
  logic [lspg_pkg::RGB_W-1:0]  rdata, old_col, wcol, emit_col, wb_col;
  logic                        ram_we;

  always_comb begin
    if (count_q == '0) begin
      n_eff = lspg_pkg::CNT_W'(1);
    end else if (count_q > lspg_pkg::MAX_COUNT) begin
      n_eff = lspg_pkg::MAX_COUNT;
    end else begin
      n_eff = count_q;
    end
  end
  assign n_m1 = lspg_pkg::IDX_W'(n_eff - lspg_pkg::CNT_W'(1));

  // The pipeline moves whenever the output register is free or being taken.
  assign adv   = !out_valid_q || !out_stall_i;
  assign issue = (state_q == lspg_pkg::ST_RUN) && adv;

  // Configuration port.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= lspg_pkg::MODE_RESET;
      solid_q <= lspg_pkg::SOLID_RESET;
      count_q <= lspg_pkg::COUNT_RESET;
    end else if (cfg_we_i) begin
      unique case (lspg_pkg::cfg_reg_e'(cfg_index_i))
        lspg_pkg::CFG_MODE:        mode_q  <= cfg_data_i[lspg_pkg::MODE_W-1:0];
        lspg_pkg::CFG_SOLID_COLOR: solid_q <= cfg_data_i;
        lspg_pkg::CFG_PIXEL_COUNT: count_q <= cfg_data_i[lspg_pkg::CNT_W-1:0];
        default: ;
      endcase
    end
  end

  // Sequencer: counters are brought into range when a tick is taken and
  // advanced as the last pixel of the frame leaves for the RAM.
  always_comb begin
    state_d    = state_q;
    step_d     = step_q;
    phase_d    = phase_q;
    round_d    = round_q;
    pix_d      = pix_q;
    pm3_d      = pm3_q;
    acc_d      = acc_q;
    racc_d     = racc_q;
    div_start  = 1'b0;
    in_stall_o = 1'b1;
    s_pre      = restart_i ? '0 : step_q;
    ph_pre     = (restart_i || phase_q >= lspg_pkg::CHASE_PHASES) ? 2'd0 : phase_q;
    rd_pre     = restart_i ? '0 : round_q;
    s_inc      = step_q + lspg_pkg::STEP_W'(1);
    r_inc      = round_q + 4'd1;
    rsum       = {1'b0, racc_q} + {1'b0, div_res.rem};

    unique case (state_q)
      lspg_pkg::ST_IDLE: begin
        in_stall_o = s1_vld_q;
        if (in_valid_i && !s1_vld_q) begin
          div_start = 1'b1;
          state_d   = lspg_pkg::ST_DIV;
          phase_d   = ph_pre;
          round_d   = rd_pre;
          step_d    = s_pre;
          case (mode_q) inside
            lspg_pkg::MODE_WIPE: begin
              if (s_pre >= lspg_pkg::STEP_W'(n_eff)) step_d = '0;
            end
            lspg_pkg::MODE_RAINBOW, lspg_pkg::MODE_CHASE_RB: begin
              if (s_pre >= lspg_pkg::STEP_W'(256)) step_d = '0;
            end
            lspg_pkg::MODE_CYCLE: begin
              if (s_pre >= lspg_pkg::CYCLE_STEPS) step_d = '0;
            end
            lspg_pkg::MODE_CHASE: begin
              if (rd_pre >= lspg_pkg::CHASE_ROUNDS) round_d = '0;
            end
            default: ;
          endcase
        end
      end
      lspg_pkg::ST_DIV: begin
        if (div_res.done) begin
          state_d = lspg_pkg::ST_RUN;
          pix_d   = '0;
          pm3_d   = '0;
          acc_d   = '0;
          racc_d  = '0;
        end
      end
      lspg_pkg::ST_RUN: begin
        if (adv) begin
          pix_d = pix_q + lspg_pkg::IDX_W'(1);
          pm3_d = (pm3_q == 2'd2) ? 2'd0 : pm3_q + 2'd1;
          if (rsum >= {1'b0, n_eff}) begin
            racc_d = lspg_pkg::CNT_W'(rsum - {1'b0, n_eff});
            acc_d  = acc_q + div_res.quot + lspg_pkg::QUOT_W'(1);
          end else begin
            racc_d = lspg_pkg::CNT_W'(rsum);
            acc_d  = acc_q + div_res.quot;
          end
          if (pix_q == n_m1) begin
            state_d = lspg_pkg::ST_IDLE;
            case (mode_q)
              lspg_pkg::MODE_WIPE: begin
                step_d = (s_inc >= lspg_pkg::STEP_W'(n_eff)) ? '0 : s_inc;
              end
              lspg_pkg::MODE_RAINBOW: begin
                step_d = lspg_pkg::STEP_W'(s_inc[7:0]);
              end
              lspg_pkg::MODE_CYCLE: begin
                step_d = (s_inc >= lspg_pkg::CYCLE_STEPS) ? '0 : s_inc;
              end
              lspg_pkg::MODE_CHASE: begin
                if (phase_q == lspg_pkg::CHASE_PHASES - 2'd1) begin
                  phase_d = '0;
                  round_d = (r_inc >= lspg_pkg::CHASE_ROUNDS) ? '0 : r_inc;
                end else begin
                  phase_d = phase_q + 2'd1;
                end
              end
              lspg_pkg::MODE_CHASE_RB: begin
                if (phase_q == lspg_pkg::CHASE_PHASES - 2'd1) begin
                  phase_d = '0;
                  step_d  = lspg_pkg::STEP_W'(s_inc[7:0]);
                end else begin
                  phase_d = phase_q + 2'd1;
                end
              end
              default: ;
            endcase
          end
        end
      end
      default: state_d = lspg_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= lspg_pkg::ST_IDLE;
      step_q  <= '0;
      phase_q <= '0;
      round_q <= '0;
      pix_q   <= '0;
      pm3_q   <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
      phase_q <= phase_d;
      round_q <= round_d;
      pix_q   <= pix_d;
      pm3_q   <= pm3_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q  <= acc_d;
    racc_q <= racc_d;
  end

  lspg_div u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start),
    .divisor_i (n_eff),
    .res_o     (div_res)
  );

  // Issue stage: wheel position and chase membership of the pixel being read.
  // A chase pixel is lit when its index sits on the current phase modulo 3.
  assign lit0 = (pm3_q == phase_q);
  assign ci   = pix_q - lspg_pkg::IDX_W'(phase_q);
  assign csum = 9'(ci) + 9'(step_q[7:0]);
  assign cmod = (csum >= lspg_pkg::WHEEL_SPAN) ? csum - lspg_pkg::WHEEL_SPAN : csum;

  always_comb begin
    case (mode_q)
      lspg_pkg::MODE_CYCLE:    wpos0 = acc_q[7:0] + step_q[7:0];
      lspg_pkg::MODE_CHASE_RB: wpos0 = cmod[7:0];
      default:                 wpos0 = lspg_pkg::CH_W'(pix_q) + step_q[7:0];
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q    <= 1'b0;
      out_valid_q <= 1'b0;
      ent_vld_q   <= '0;
    end else begin
      if (adv) begin
        s1_vld_q    <= issue;
        out_valid_q <= s1_vld_q;
      end
      if (ram_we) begin
        ent_vld_q[p1_q] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (issue) begin
      p1_q    <= pix_q;
      last1_q <= (pix_q == n_m1);
      lit1_q  <= lit0;
      hit1_q  <= (lspg_pkg::STEP_W'(pix_q) == step_q);
      ent1_q  <= ent_vld_q[pix_q];
      wpos1_q <= wpos0;
    end
    if (adv && s1_vld_q) begin
      out_idx_q  <= p1_q;
      out_rgb_q  <= emit_col;
      out_last_q <= last1_q;
    end
  end

  lspg_ram #(
    .Width (lspg_pkg::RGB_W),
    .Depth (lspg_pkg::MAX_PIXELS)
  ) u_frame_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (p1_q),
    .wdata_i (wb_col),
    .re_i    (issue),
    .raddr_i (pix_q),
    .rdata_o (rdata)
  );

  // Recolour stage: what is shown and what goes back into the buffer.
  // Chase pixels are shown lit and then stored dark again.
  assign old_col = ent1_q ? rdata : '0;
  assign wcol    = lspg_pkg::wheel(wpos1_q);
  assign ram_we  = adv && s1_vld_q;

  always_comb begin
    emit_col = old_col;
    wb_col   = old_col;
    case (mode_q) inside
      lspg_pkg::MODE_WIPE: begin
        if (hit1_q) begin
          emit_col = solid_q;
          wb_col   = solid_q;
        end
      end
      lspg_pkg::MODE_RAINBOW, lspg_pkg::MODE_CYCLE: begin
        emit_col = wcol;
        wb_col   = wcol;
      end
      lspg_pkg::MODE_CHASE: begin
        if (lit1_q) begin
          emit_col = solid_q;
          wb_col   = '0;
        end
      end
      lspg_pkg::MODE_CHASE_RB: begin
        if (lit1_q) begin
          emit_col = wcol;
          wb_col   = '0;
        end
      end
      default: ;
    endcase
  end

  assign out_valid_o   = out_valid_q;
  assign pixel_index_o = out_idx_q;
  assign red_o         = out_rgb_q[23:16];
  assign green_o       = out_rgb_q[15:8];
  assign blue_o        = out_rgb_q[7:0];
  assign last_pixel_o  = out_last_q;

  // The frame-end marker always sits on the final pixel of the strip.
  a_last_on_final : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && last_pixel_o |-> pixel_index_o == n_m1)
    else $error("last pixel flag on wrong index");

  // The read pointer never runs past the strip.
  a_issue_in_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == lspg_pkg::ST_RUN |-> {1'b0, pix_q} < n_eff)
    else $error("pixel read beyond strip length");

  // The chase phase stays within its three positions.
  a_phase_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q < lspg_pkg::CHASE_PHASES)
    else $error("chase phase out of range");

  // In wipe mode the wipe position is a real pixel while the frame runs.
  a_wipe_step : assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == lspg_pkg::ST_RUN && mode_q == lspg_pkg::MODE_WIPE
      |-> step_q < lspg_pkg::STEP_W'(n_eff))
    else $error("wipe position beyond strip length");

endmodule

FILE: sim/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import lspg_pkg::*;

  localparam int unsigned RANDOM_FRAMES = 310;
  localparam int unsigned WHEEL_STEPS   = 256;
  localparam int unsigned TAIL_CYCLES   = 80;
  localparam int unsigned CYCLE_LIMIT   = 4_000_000;

  // Modes with no animation of their own.
  localparam logic [MODE_W-1:0] MODE_SPARE_LO = 3'd5;
  localparam logic [MODE_W-1:0] MODE_SPARE_HI = 3'd7;

  typedef enum bit {ROW_CFG, ROW_FRAME} row_kind_e;

  // One row of the directed table: either a register write or a frame tick.
  // Where typed is set, pixel 0 of that frame must carry first_rgb.
  typedef struct packed {
    row_kind_e         kind;
    cfg_reg_e          which;
    logic [RGB_W-1:0]  value;
    bit                restart;
    bit                typed;
    logic [RGB_W-1:0]  first_rgb;
  } script_row_t;

  typedef struct packed {
    logic [IDX_W-1:0] idx;
    logic [RGB_W-1:0] rgb;
    logic             last;
  } pixel_t;

  localparam int unsigned SCRIPT_LEN = 38;

  script_row_t script [SCRIPT_LEN] = '{
    // Rainbow straight out of reset: the first two offsets of the wheel.
    '{ROW_FRAME, CFG_MODE, 24'h0, 1'b0, 1'b1, 24'hFF0000},
    '{ROW_FRAME, CFG_MODE, 24'h0, 1'b0, 1'b1, 24'hFC0300},
    // A pixel count of zero behaves as a single pixel.
    '{ROW_CFG, CFG_PIXEL_COUNT, 24'd0, 1'b0, 1'b0, 24'h0},
    '{ROW_FRAME, CFG_MODE, 24'h0, 1'b1, 1'b1, 24'hFF0000},
    // Counts beyond the strip length are clipped to the full strip.
    '{ROW_CFG, CFG_PIXEL_COUNT, 24'd127, 1'b0, 1'b0, 24'h0},
    '{ROW_FRAME, CFG_MODE, 24'h0, 1'b0, 1'b1, 24'hFC0300},
    // Colour wipe in white, then in black.
    '{ROW_CFG, CFG_MODE, 24'(MODE_WIPE), 1'b0, 1'b0, 24'h0},
    '{ROW_CFG, CFG_SOLID_COLOR, 24'hFFFFFF, 1'b0, 1'b0, 24'h0},
    '{ROW_FRAME, CFG_MODE, 24'h0, 1'b1, 1'b1, 24'hFFFFFF},
    '{ROW_FRAME, CFG_MODE, 24'h0, 1'b0, 1'b0, 24'h0},
    '{ROW_CFG, CFG_SOLID_COLOR, 24'h000000, 1'b0, 1'b0, 24'h0},
    '{ROW_FRAME, CFG_MODE, 24'h0, 1'b0, 1'b0, 24'h0},
    // Shrinking the strip leaves the wipe position out of range.
    '{ROW_CFG, CFG_PIXEL_COUNT, 24'd3, 1'b0, 1'b0, 24'h0},
    '{ROW_FRAME, CFG_MODE, 24'h0, 1'b0, 1'b1, 24'h000000},
    '{ROW_CFG, CFG_MODE, 24'(MODE_CYCLE), 1'b0, 1'b0, 24'h0},
    '{ROW_FRAME, CFG_MODE, 24'h0, 1'b1, 1'b1, 24'hFF0000},
    '{ROW_FRAME, CFG_MODE, 24'h0, 1'b0, 1'b0, 24'h0},
    // Theater chase over a full round of phases.
    '{ROW_CFG, CFG_MODE, 24'(MODE_CHASE), 1'b0, 1'b0, 24'h0},
    '{ROW_CFG, CFG_SOLID_COLOR, 24'h123456, 1'b0, 1'b0, 24'h0},
    '{ROW_CFG, CFG_PIXEL_COUNT, 24'd64, 1'b0, 1'b0, 24'h0},
    '{ROW_FRAME, CFG_MODE, 24'h0, 1'b1, 1'b1, 24'h123456},
    '{ROW_FRAME, CFG_MODE, 24'h0, 1'b0, 1'b0, 24'h0},
    '{ROW_FRAME, CFG_MODE, 24'h0, 1'b0, 1'b0, 24'h0},
    '{ROW_FRAME, CFG_MODE, 24'h0, 1'b0, 1'b0, 24'h0},
    // Chase rainbow on two pixels: the last phase lights nothing.
    '{ROW_CFG, CFG_MODE, 24'(MODE_CHASE_RB), 1'b0, 1'b0, 24'h0},
    '{ROW_CFG, CFG_PIXEL_COUNT, 24'd2, 1'b0, 1'b0, 24'h0},
    '{ROW_FRAME, CFG_MODE, 24'h0, 1'b1, 1'b1, 24'hFF0000},
    '{ROW_FRAME, CFG_MODE, 24'h0, 1'b0, 1'b0, 24'h0},
    '{ROW_FRAME, CFG_MODE, 24'h0, 1'b0, 1'b0, 24'h0},
    // Unused modes still emit the buffer untouched.
    '{ROW_CFG, CFG_MODE, 24'(MODE_SPARE_HI), 1'b0, 1'b0, 24'h0},
    '{ROW_FRAME, CFG_MODE, 24'h0, 1'b0, 1'b0, 24'h0},
    '{ROW_FRAME, CFG_MODE, 24'h0, 1'b1, 1'b0, 24'h0},
    '{ROW_CFG, CFG_MODE, 24'(MODE_SPARE_LO), 1'b0, 1'b0, 24'h0},
    '{ROW_CFG, CFG_PIXEL_COUNT, 24'd65, 1'b0, 1'b0, 24'h0},
    '{ROW_FRAME, CFG_MODE, 24'h0, 1'b0, 1'b0, 24'h0},
    '{ROW_CFG, CFG_MODE, 24'(MODE_RAINBOW), 1'b0, 1'b0, 24'h0},
    '{ROW_CFG, CFG_PIXEL_COUNT, 24'd60, 1'b0, 1'b0, 24'h0},
    '{ROW_FRAME, CFG_MODE, 24'h0, 1'b1, 1'b1, 24'hFF0000}
  };

  logic               clk_i = 1'b0;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_stall_o;
  logic               restart_i;
  logic               out_valid_o;
  logic               out_stall_i;
  logic [IDX_W-1:0]   pixel_index_o;
  logic [CH_W-1:0]    red_o;
  logic [CH_W-1:0]    green_o;
  logic [CH_W-1:0]    blue_o;
  logic               last_pixel_o;
  logic               cfg_we_i;
  logic [1:0]         cfg_index_i;
  logic [RGB_W-1:0]   cfg_data_i;

  // Shadow of the block's state, advanced once per accepted frame tick.
  logic [RGB_W-1:0]   strip_mem [MAX_PIXELS];
  int unsigned        anim_step;
  int unsigned        chase_ph;
  int unsigned        chase_rnd;
  logic [MODE_W-1:0]  cfg_mode;
  logic [RGB_W-1:0]   cfg_solid;
  logic [CNT_W-1:0]   cfg_count;

  pixel_t             pixel_q [$];
  int unsigned        mismatches = 0;
  int unsigned        cycles = 0;
  bit                 calm_phase = 1'b0;

  led_strip_pattern_generator u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .restart_i     (restart_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .pixel_index_o (pixel_index_o),
    .red_o         (red_o),
    .green_o       (green_o),
    .blue_o        (blue_o),
    .last_pixel_o  (last_pixel_o),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Colour wheel in three linear segments: red to green, green to blue and
  // blue back to red.
  function automatic logic [RGB_W-1:0] hue_to_rgb(input int unsigned pos);
    int unsigned p;
    int unsigned r;
    int unsigned g;
    int unsigned b;
    p = 255 - (pos % 256);
    if (p < 85) begin
      r = 255 - 3 * p;
      g = 0;
      b = 3 * p;
    end else if (p < 170) begin
      p -= 85;
      r = 0;
      g = 3 * p;
      b = 255 - 3 * p;
    end else begin
      p -= 170;
      r = 3 * p;
      g = 255 - 3 * p;
      b = 0;
    end
    return {r[7:0], g[7:0], b[7:0]};
  endfunction

  // Lights or clears every third pixel from the chase phase onwards.
  function automatic void paint_chase(input int unsigned n, input bit lit, input bit hued);
    int unsigned pos;
    for (int unsigned i = 0; i < n; i += 3) begin
      pos = i + chase_ph;
      if (pos < n) begin
        if (!lit)
          strip_mem[pos] = '0;
        else if (hued)
          strip_mem[pos] = hue_to_rgb((i + anim_step) % WHEEL_SPAN);
        else
          strip_mem[pos] = cfg_solid;
      end
    end
  endfunction

  // Advances the animation by one frame and queues the pixels it shows.
  function automatic void render_frame(input bit restart, input bit typed,
                                       input logic [RGB_W-1:0] first_rgb);
    int unsigned n;
    int unsigned base;
    bit          chase;
    n = cfg_count;
    if (n < 1) n = 1;
    if (n > MAX_PIXELS) n = MAX_PIXELS;
    chase = 1'b0;
    if (restart) begin
      anim_step = 0;
      chase_ph  = 0;
      chase_rnd = 0;
    end
    if (chase_ph >= CHASE_PHASES) chase_ph = 0;

    case (cfg_mode)
      MODE_WIPE: begin
        if (anim_step >= n) anim_step = 0;
        strip_mem[anim_step] = cfg_solid;
        anim_step++;
      end
      MODE_RAINBOW: begin
        if (anim_step >= WHEEL_STEPS) anim_step = 0;
        for (int unsigned i = 0; i < n; i++)
          strip_mem[i] = hue_to_rgb(i + anim_step);
        anim_step++;
      end
      MODE_CYCLE: begin
        if (anim_step >= CYCLE_STEPS) anim_step = 0;
        for (int unsigned i = 0; i < n; i++)
          strip_mem[i] = hue_to_rgb((i * 256) / n + anim_step);
        anim_step++;
      end
      MODE_CHASE: begin
        if (chase_rnd >= CHASE_ROUNDS) chase_rnd = 0;
        paint_chase(n, 1'b1, 1'b0);
        chase = 1'b1;
      end
      MODE_CHASE_RB: begin
        if (anim_step >= WHEEL_STEPS) anim_step = 0;
        paint_chase(n, 1'b1, 1'b1);
        chase = 1'b1;
      end
      default: ;
    endcase

    base = pixel_q.size();
    for (int unsigned i = 0; i < n; i++)
      pixel_q.push_back('{idx: i[IDX_W-1:0], rgb: strip_mem[i], last: (i + 1 == n)});
    if (typed) pixel_q[base].rgb = first_rgb;

    if (chase) begin
      paint_chase(n, 1'b0, 1'b0);
      chase_ph++;
      if (chase_ph >= CHASE_PHASES) begin
        chase_ph = 0;
        if (cfg_mode == MODE_CHASE) begin
          chase_rnd++;
          if (chase_rnd >= CHASE_ROUNDS) chase_rnd = 0;
        end else begin
          anim_step++;
        end
      end
    end
    if (cfg_mode == MODE_WIPE && anim_step >= n) anim_step = 0;
    if (cfg_mode == MODE_RAINBOW || cfg_mode == MODE_CHASE_RB) anim_step %= WHEEL_STEPS;
    if (cfg_mode == MODE_CYCLE && anim_step >= CYCLE_STEPS) anim_step = 0;
  endfunction

  // Mostly back to back, now and then a short pause, rarely a long one.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (calm_phase || r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 30);
  endfunction

  function automatic void compare(input string name, input logic [31:0] want,
                                  input logic [31:0] got);
    if (want !== got) begin
      mismatches++;
      $error("%s: expected %0d, got %0d", name, want, got);
    end
  endfunction

  // Every pixel word leaving the block is matched against the oldest one
  // still owed.
  always @(posedge clk_i) begin : pixel_monitor
    pixel_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pixel_q.size() == 0) begin
        mismatches++;
        $error("pixel word with none expected, index %0d", pixel_index_o);
      end else begin
        want = pixel_q.pop_front();
        compare("pixel_index", 32'(want.idx), 32'(pixel_index_o));
        compare("red", 32'(want.rgb[23:16]), 32'(red_o));
        compare("green", 32'(want.rgb[15:8]), 32'(green_o));
        compare("blue", 32'(want.rgb[7:0]), 32'(blue_o));
        compare("last_pixel", 32'(want.last), 32'(last_pixel_o));
      end
    end
  end

  // Back-pressure on the pixel stream, switched off during calm phases.
  initial begin : stall_driver
    int unsigned hold;
    out_stall_i <= 1'b0;
    @(posedge clk_i);
    forever begin
      hold = pick_gap();
      if (hold != 0) begin
        out_stall_i <= 1'b1;
        repeat (hold) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
  end

  // Drops the frame valid and waits for every owed pixel to come out.
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (pixel_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_cfg(input cfg_reg_e which, input logic [RGB_W-1:0] value);
    wait_idle();
    cfg_we_i    <= 1'b1;
    cfg_index_i <= which;
    cfg_data_i  <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    case (which)
      CFG_MODE:        cfg_mode  = value[MODE_W-1:0];
      CFG_SOLID_COLOR: cfg_solid = value;
      CFG_PIXEL_COUNT: cfg_count = value[CNT_W-1:0];
      default: ;
    endcase
  endtask

  task automatic send_frame(input bit restart, input bit typed,
                            input logic [RGB_W-1:0] first_rgb);
    int unsigned gap;
    gap = pick_gap();
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    restart_i  <= restart;
    do @(posedge clk_i); while (in_stall_o);
    render_frame(restart, typed, first_rgb);
  endtask

  function automatic logic [MODE_W-1:0] pick_mode();
    if ($urandom_range(0, 9) == 0) return MODE_W'($urandom_range(5, 7));
    return MODE_W'($urandom_range(0, 4));
  endfunction

  // Short strips most of the time, the full strip and the clipped counts less
  // often.
  function automatic logic [CNT_W-1:0] pick_count();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return CNT_W'($urandom_range(1, 8));
    if (r < 75) return CNT_W'($urandom_range(9, 40));
    if (r < 85) return CNT_W'($urandom_range(41, 64));
    if (r < 90) return MAX_COUNT;
    if (r < 94) return '0;
    return CNT_W'($urandom_range(65, 127));
  endfunction

  initial begin : stimulus
    int unsigned sent;
    int unsigned run_len;
    rst_ni      <= 1'b0;
    in_valid_i  <= 1'b0;
    restart_i   <= 1'b0;
    cfg_we_i    <= 1'b0;
    cfg_index_i <= CFG_MODE;
    cfg_data_i  <= '0;
    foreach (strip_mem[k]) strip_mem[k] = '0;
    anim_step = 0;
    chase_ph  = 0;
    chase_rnd = 0;
    cfg_mode  = MODE_RESET;
    cfg_solid = SOLID_RESET;
    cfg_count = COUNT_RESET;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (script[k]) begin
      if (script[k].kind == ROW_CFG)
        write_cfg(script[k].which, script[k].value);
      else
        send_frame(script[k].restart, script[k].typed, script[k].first_rgb);
    end

    // Random phases: fresh settings on some registers, then a run of frame
    // ticks with the odd restart thrown in.
    sent = 0;
    while (sent < RANDOM_FRAMES) begin
      calm_phase = ($urandom_range(0, 4) == 0);
      if ($urandom_range(0, 2) != 0) write_cfg(CFG_MODE, RGB_W'(pick_mode()));
      if ($urandom_range(0, 1) != 0) write_cfg(CFG_SOLID_COLOR, RGB_W'($urandom()));
      if ($urandom_range(0, 1) != 0) write_cfg(CFG_PIXEL_COUNT, RGB_W'(pick_count()));
      run_len = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 70) : $urandom_range(3, 15);
      if (run_len > RANDOM_FRAMES - sent) run_len = RANDOM_FRAMES - sent;
      repeat (run_len) begin
        send_frame($urandom_range(0, 7) == 0, 1'b0, '0);
        sent++;
      end
    end

    calm_phase = 1'b0;
    wait_idle();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (mismatches == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule
